// ===== sv/snlc_pkg.sv =====
// shared types and constants for the scrambler / nrzi line coder
package snlc_pkg;

   localparam int unsigned ShiftWidth = 17;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CsrIndexWidth = 2;
   localparam int unsigned CsrDataWidth  = ShiftWidth;

   // scrambler taps for 1 + x^12 + x^17
   localparam int unsigned TapA = 11;
   localparam int unsigned TapB = 16;

   // register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_DIRECTION       = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_SCRAMBLE_ENABLE = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_NRZI_ENABLE     = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_SCRAMBLER_SEED  = 2'd3;

   localparam logic DIR_TRANSMIT = 1'b0;
   localparam logic DIR_RECEIVE  = 1'b1;

   localparam logic [ShiftWidth-1:0] SEED_RESET = '0;
   localparam logic LEVEL_IDLE = 1'b1;

   typedef struct packed {
      logic direction;
      logic scramble_enable;
      logic nrzi_enable;
   } mode_type;

endpackage

// ===== sv/snlc_coder.sv =====
// one byte of nrzi coding and scrambling, bit 0 first, as combinational logic
module snlc_coder (
   input  snlc_pkg::mode_type                   mode,
   input  logic [snlc_pkg::ByteWidth-1:0]       data_byte,
   input  logic [snlc_pkg::ShiftWidth-1:0]      shift_start,
   input  logic                                 level_start,
   output logic [snlc_pkg::ByteWidth-1:0]       coded_byte,
   output logic [snlc_pkg::ShiftWidth-1:0]      shift_end,
   output logic                                 level_end
);

   always_comb begin
      logic [snlc_pkg::ShiftWidth-1:0] sr;
      logic                            lvl;
      logic                            bit_v;
      logic                            rx;
      logic                            fb;
      sr  = shift_start;
      lvl = level_start;
      rx  = 1'b0;
      coded_byte = '0;
      for (int b = 0; b < snlc_pkg::ByteWidth; b++) begin
         bit_v = data_byte[b];
         fb    = sr[snlc_pkg::TapA] ^ sr[snlc_pkg::TapB];
         if (mode.direction == snlc_pkg::DIR_TRANSMIT) begin
            if (mode.nrzi_enable) begin
               // zero toggles the line level
               lvl   = lvl ^ ~bit_v;
               bit_v = lvl;
            end
            if (mode.scramble_enable) begin
               bit_v = bit_v ^ fb;
               sr    = {sr[snlc_pkg::ShiftWidth-2:0], bit_v};
            end
         end else begin
            if (mode.scramble_enable) begin
               rx    = bit_v;
               bit_v = rx ^ fb;
               sr    = {sr[snlc_pkg::ShiftWidth-2:0], rx};
            end
            if (mode.nrzi_enable) begin
               rx    = bit_v;
               bit_v = ~(rx ^ lvl);
               lvl   = rx;
            end
         end
         coded_byte[b] = bit_v;
      end
      shift_end = sr;
      level_end = lvl;
   end

endmodule

// ===== sv/scrambler_nrzi_line_coder.sv =====
// top level of the byte-wide scrambler / nrzi line coder
//
//   channel  | ports                                                  | direction
//   ---------+--------------------------------------------------------+----------
//   request  | req_valid/ready, data_byte, last_of_frame, reload_seed | in
//   response | rsp_valid/ready, coded_byte                            | out
//   csr      | csr_write_enable, csr_index, csr_data                  | in
//
// one request per cycle while the response is not stalled; a request is held
// in the input register, then its coded byte goes to the response register,
// which drives rsp_valid. scrambler register and nrzi level are updated when
// a request moves from the input register to the response register. reset
// is synchronous: it clears the valid flags, selects transmit with scrambling
// and nrzi on, loads the reset seed and sets the line level to one. a stalled
// response holds the input register, which keeps accepting until it is full.
module scrambler_nrzi_line_coder (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [snlc_pkg::ByteWidth-1:0]         req_data_byte,
   input  logic                                   req_last_of_frame,
   input  logic                                   req_reload_seed,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [snlc_pkg::ByteWidth-1:0]         rsp_coded_byte,
   input  logic                                   csr_write_enable,
   input  logic [snlc_pkg::CsrIndexWidth-1:0]     csr_index,
   input  logic [snlc_pkg::CsrDataWidth-1:0]      csr_data
);

   snlc_pkg::mode_type                   mode_ff;
   logic [snlc_pkg::ShiftWidth-1:0]      seed_ff;

   logic                                 in_valid_ff;
   logic [snlc_pkg::ByteWidth-1:0]       in_data_ff;
   logic                                 in_last_ff;
   logic                                 in_reload_ff;

   logic                                 out_valid_ff;
   logic [snlc_pkg::ByteWidth-1:0]       out_data_ff;

   logic [snlc_pkg::ShiftWidth-1:0]      shift_ff;
   logic                                 level_ff;

   logic [snlc_pkg::ShiftWidth-1:0]      shift_start;
   logic [snlc_pkg::ShiftWidth-1:0]      shift_in;
   logic                                 level_coded;
   logic                                 level_in;
   logic [snlc_pkg::ByteWidth-1:0]       coded_in;
   logic                                 advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   // reload happens before the byte is coded
   assign shift_start = in_reload_ff ? seed_ff : shift_ff;

   snlc_coder u_coder (
      .mode        (mode_ff),
      .data_byte   (in_data_ff),
      .shift_start (shift_start),
      .level_start (level_ff),
      .coded_byte  (coded_in),
      .shift_end   (shift_in),
      .level_end   (level_coded)
   );

   assign level_in = in_last_ff ? snlc_pkg::LEVEL_IDLE : level_coded;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '{direction: snlc_pkg::DIR_TRANSMIT,
                      scramble_enable: 1'b1, nrzi_enable: 1'b1};
         seed_ff <= snlc_pkg::SEED_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            snlc_pkg::CSR_DIRECTION:       mode_ff.direction       <= csr_data[0];
            snlc_pkg::CSR_SCRAMBLE_ENABLE: mode_ff.scramble_enable <= csr_data[0];
            snlc_pkg::CSR_NRZI_ENABLE:     mode_ff.nrzi_enable     <= csr_data[0];
            snlc_pkg::CSR_SCRAMBLER_SEED:  seed_ff                 <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         shift_ff     <= snlc_pkg::SEED_RESET;
         level_ff     <= snlc_pkg::LEVEL_IDLE;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            shift_ff     <= shift_in;
            level_ff     <= level_in;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff   <= req_data_byte;
         in_last_ff   <= req_last_of_frame;
         in_reload_ff <= req_reload_seed;
      end
      if (advance) begin
         out_data_ff <= coded_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_coded_byte = out_data_ff;

endmodule
